// File: rtl/core/ssf_pkg.sv
// shared item types for the seek steering force block
package ssf_pkg;

  // command codes
  localparam logic [1:0] CMD_SEEK  = 2'd0;
  localparam logic [1:0] CMD_CTRL  = 2'd1;
  localparam logic [1:0] CMD_STILL = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] position_z;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
  } ssf_in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] new_velocity_x;
    logic signed [31:0] new_velocity_y;
    logic signed [31:0] new_velocity_z;
  } ssf_out_t;

endpackage

// File: rtl/core/ssf_isqrt.sv
// pipelined integer square root, one root bit per stage
module ssf_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [31:0]       out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int NS = 32;

  logic              vld_r  [NS];
  logic [63:0]       rem_r  [NS];
  logic [31:0]       root_r [NS];
  logic [SIDE_W-1:0] side_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int B = NS - 1 - k;
    logic              vld_s;
    logic [63:0]       rem_s;
    logic [31:0]       root_s;
    logic [SIDE_W-1:0] side_s;
    logic [64:0]       trial;
    logic              take;

    if (k == 0) begin : g_head
      assign vld_s  = in_valid;
      assign rem_s  = in_rad;
      assign root_s = '0;
      assign side_s = in_side;
    end else begin : g_body
      assign vld_s  = vld_r[k-1];
      assign rem_s  = rem_r[k-1];
      assign root_s = root_r[k-1];
      assign side_s = side_r[k-1];
    end

    // (root + 2^b)^2 - root^2
    assign trial = (65'(root_s) << (B + 1)) | (65'(1) << (2 * B));
    assign take  = {1'b0, rem_s} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? rem_s - trial[63:0] : rem_s;
        root_r[k] <= take ? (root_s | (32'(1) << B)) : root_s;
        side_r[k] <= side_s;
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

// File: rtl/core/ssf_div.sv
// pipelined three-lane restoring divider with a shared divisor
module ssf_div #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2:0][61:0]  in_num,
  input  logic [31:0]       in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [2:0][30:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int NS = 31;

  logic              vld_r  [NS];
  logic [2:0][61:0]  rem_r  [NS];
  logic [2:0][30:0]  quo_r  [NS];
  logic [31:0]       den_r  [NS];
  logic [SIDE_W-1:0] side_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int B = NS - 1 - k;
    logic              vld_s;
    logic [2:0][61:0]  rem_s;
    logic [2:0][61:0]  rem_n;
    logic [2:0][30:0]  quo_s;
    logic [2:0][30:0]  quo_n;
    logic [31:0]       den_s;
    logic [SIDE_W-1:0] side_s;
    logic [62:0]       sub;

    if (k == 0) begin : g_head
      assign vld_s  = in_valid;
      assign rem_s  = in_num;
      assign quo_s  = '0;
      assign den_s  = in_den;
      assign side_s = in_side;
    end else begin : g_body
      assign vld_s  = vld_r[k-1];
      assign rem_s  = rem_r[k-1];
      assign quo_s  = quo_r[k-1];
      assign den_s  = den_r[k-1];
      assign side_s = side_r[k-1];
    end

    assign sub = 63'(den_s) << B;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if ({1'b0, rem_s[l]} >= sub) begin
          rem_n[l] = rem_s[l] - sub[61:0];
          quo_n[l] = quo_s[l] | (31'(1) << B);
        end else begin
          rem_n[l] = rem_s[l];
          quo_n[l] = quo_s[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_n;
        quo_r[k]  <= quo_n;
        den_r[k]  <= den_s;
        side_r[k] <= side_s;
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_quo   = quo_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

// File: rtl/core/seek_steering_force_top.sv
// seek steering force block: top level with register port and full pipeline
//
// One item enters per cycle and one result leaves per cycle while no result
// waits at a stalled output. The pipeline is set by two vector length units
// (32-stage square roots, one root bit per stage) and two 31-stage dividers
// that resize a vector to a given length. A stall at the output freezes the
// whole pipeline, so in_stall follows out_stall while a result waits. In
// seek mode the force is target minus position scaled to speed_limit, minus
// the velocity, clamped in length to force_limit and saturated to 32 bits;
// any other command gives a zero force. Still mode, also taken for code 3,
// damps the velocity to a tenth (truncated toward zero) when its length
// exceeds 1.0 and zeroes it otherwise. Registers: speed_limit at byte
// address 0, force_limit at byte address 4, both 31 bits, readable.
// Write them only while the pipeline is empty.
module seek_steering_force_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  // item input
  input  logic            in_valid,
  output logic            in_stall,
  input  ssf_pkg::ssf_in_t  in_data,
  // item output
  output logic            out_valid,
  input  logic            out_stall,
  output ssf_pkg::ssf_out_t out_data,
  // register port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam logic [63:0] STILL_THR = 64'(1) << (2 * FRAC_BITS);
  localparam logic [31:0] RECIP10   = 32'hCCCCCCCD;
  localparam logic [30:0] SPEED_RST = 31'd65536;
  localparam logic [30:0] FORCE_RST = 31'd131072;
  localparam logic        REG_SPEED = 1'b0;
  localparam logic        REG_FORCE = 1'b1;

  typedef logic [2:0][30:0] vec31_t;
  typedef logic [2:0][31:0] vec32_t;
  typedef logic [2:0][32:0] vec33_t;
  typedef logic [2:0][61:0] vec62_t;
  typedef logic [2:0][63:0] vec64_t;

  // side data carried through the units
  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] dneg;
    vec31_t     n;
    vec32_t     v;
    vec32_t     nv;
  } side_a_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] dneg;
    logic       dzero;
    vec32_t     v;
    vec32_t     nv;
  } side_b_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] sneg;
    vec33_t     st;
    vec32_t     nv;
    vec31_t     n;
    logic [4:0] up;
    logic [1:0] down;
  } side_c_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] sneg;
    vec33_t     st;
    vec32_t     nv;
    logic       clamp;
  } side_d_t;

  function automatic logic [32:0] abs33(input logic [32:0] x);
    return x[32] ? 33'(-x) : x;
  endfunction

  function automatic logic [32:0] max3(input vec33_t m);
    logic [32:0] a;
    a = (m[1] > m[0]) ? m[1] : m[0];
    return (m[2] > a) ? m[2] : a;
  endfunction

  // right shift that brings the largest magnitude below 2^31
  function automatic logic [1:0] down_of(input logic [32:0] mx);
    return mx[32] ? 2'd2 : (mx[31] ? 2'd1 : 2'd0);
  endfunction

  // left shift that brings it to at least 2^30
  function automatic logic [4:0] up_of(input logic [32:0] mx, input logic [1:0] dn);
    logic [30:0] s;
    logic [4:0]  u;
    s = 31'(mx >> dn);
    u = '0;
    for (int i = 0; i < 31; i++) begin
      if (s[i]) u = 5'(30 - i);
    end
    return u;
  endfunction

  // ---------------------------------------------------------------- registers
  logic [30:0] speed_r;
  logic [30:0] force_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_RST;
      force_r <= FORCE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_SPEED: speed_r <= pwdata[30:0];
        REG_FORCE: force_r <= pwdata[30:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SPEED: prdata = {1'b0, speed_r};
      REG_FORCE: prdata = {1'b0, force_r};
      default:   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // ---------------------------------------------------------------- flow
  // the whole pipeline moves unless a finished result is held at the output
  logic adv;
  logic out_valid_r;
  ssf_pkg::ssf_out_t out_data_r;

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- s1: difference, |v|
  logic       s1_vld_r;
  logic [1:0] s1_cmd_r;
  vec33_t     s1_d_r;
  vec32_t     s1_v_r;
  vec32_t     s1_vm_r;
  vec32_t     in_t, in_p, in_v;

  assign in_t = {in_data.target_z, in_data.target_y, in_data.target_x};
  assign in_p = {in_data.position_z, in_data.position_y, in_data.position_x};
  assign in_v = {in_data.velocity_z, in_data.velocity_y, in_data.velocity_x};

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (adv) s1_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r <= in_data.command;
      for (int i = 0; i < 3; i++) begin
        s1_d_r[i]  <= {in_t[i][31], in_t[i]} - {in_p[i][31], in_p[i]};
        s1_v_r[i]  <= in_v[i];
        s1_vm_r[i] <= in_v[i][31] ? 32'(-in_v[i]) : in_v[i];
      end
    end
  end

  // ---------------------------------------------------------------- s2: |d|, v squares, v / 10
  logic       s2_vld_r;
  logic [1:0] s2_cmd_r;
  vec33_t     s2_m_r;
  logic [2:0] s2_dneg_r;
  vec32_t     s2_v_r;
  vec64_t     s2_sq_r;
  logic [2:0][28:0] s2_q10_r;
  logic [2:0][63:0] s1_rp;

  always_comb begin
    for (int i = 0; i < 3; i++) s1_rp[i] = 64'(s1_vm_r[i]) * 64'(RECIP10);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (adv) s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd_r <= s1_cmd_r;
      s2_v_r   <= s1_v_r;
      for (int i = 0; i < 3; i++) begin
        s2_m_r[i]    <= abs33(s1_d_r[i]);
        s2_dneg_r[i] <= s1_d_r[i][32];
        s2_sq_r[i]   <= 64'(s1_vm_r[i]) * 64'(s1_vm_r[i]);
        s2_q10_r[i]  <= s1_rp[i][63:35];
      end
    end
  end

  // ---------------------------------------------------------------- s3: max, square sum
  logic        s3_vld_r;
  logic [1:0]  s3_cmd_r;
  vec33_t      s3_m_r;
  logic [32:0] s3_mx_r;
  logic [2:0]  s3_dneg_r;
  vec32_t      s3_v_r;
  logic [63:0] s3_sum_r;
  logic [2:0][28:0] s3_q10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (adv) s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cmd_r  <= s2_cmd_r;
      s3_m_r    <= s2_m_r;
      s3_mx_r   <= max3(s2_m_r);
      s3_dneg_r <= s2_dneg_r;
      s3_v_r    <= s2_v_r;
      s3_sum_r  <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
      s3_q10_r  <= s2_q10_r;
    end
  end

  // ---------------------------------------------------------------- s4: shift amounts, damped velocity
  logic       s4_vld_r;
  logic [1:0] s4_cmd_r;
  vec33_t     s4_m_r;
  logic [1:0] s4_down_r;
  logic [4:0] s4_up_r;
  logic [2:0] s4_dneg_r;
  vec32_t     s4_v_r;
  vec32_t     s4_nv_r;
  vec32_t     s3_nv;
  logic [1:0] s3_down;

  assign s3_down = down_of(s3_mx_r);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s3_cmd_r == ssf_pkg::CMD_SEEK || s3_cmd_r == ssf_pkg::CMD_CTRL) begin
        s3_nv[i] = s3_v_r[i];
      end else if (s3_sum_r > STILL_THR) begin
        s3_nv[i] = s3_v_r[i][31] ? 32'(-{3'b000, s3_q10_r[i]}) : {3'b000, s3_q10_r[i]};
      end else begin
        s3_nv[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else if (adv) s4_vld_r <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_cmd_r  <= s3_cmd_r;
      s4_m_r    <= s3_m_r;
      s4_down_r <= s3_down;
      s4_up_r   <= up_of(s3_mx_r, s3_down);
      s4_dneg_r <= s3_dneg_r;
      s4_v_r    <= s3_v_r;
      s4_nv_r   <= s3_nv;
    end
  end

  // ---------------------------------------------------------------- s5: normalize
  logic       s5_vld_r;
  side_a_t    s5_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else if (adv) s5_vld_r <= s4_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_side_r.cmd  <= s4_cmd_r;
      s5_side_r.dneg <= s4_dneg_r;
      s5_side_r.v    <= s4_v_r;
      s5_side_r.nv   <= s4_nv_r;
      for (int i = 0; i < 3; i++) begin
        s5_side_r.n[i] <= 31'((s4_m_r[i] >> s4_down_r) << s4_up_r);
      end
    end
  end

  // ---------------------------------------------------------------- s6: squares
  logic    s6_vld_r;
  side_a_t s6_side_r;
  vec62_t  s6_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_vld_r <= 1'b0;
    else if (adv) s6_vld_r <= s5_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_side_r <= s5_side_r;
      for (int i = 0; i < 3; i++) begin
        s6_sq_r[i] <= 62'(s5_side_r.n[i]) * 62'(s5_side_r.n[i]);
      end
    end
  end

  // ---------------------------------------------------------------- s7: sum of squares
  logic        s7_vld_r;
  side_a_t     s7_side_r;
  logic [63:0] s7_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_vld_r <= 1'b0;
    else if (adv) s7_vld_r <= s6_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_side_r <= s6_side_r;
      s7_sum_r  <= 64'(s6_sq_r[0]) + 64'(s6_sq_r[1]) + 64'(s6_sq_r[2]);
    end
  end

  // ---------------------------------------------------------------- length of the desired direction
  logic        r1_vld;
  logic [31:0] r1_root;
  side_a_t     r1_side;

  ssf_isqrt #(.SIDE_W($bits(side_a_t))) u_len_des (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s7_vld_r),
    .in_rad    (s7_sum_r),
    .in_side   (s7_side_r),
    .out_valid (r1_vld),
    .out_root  (r1_root),
    .out_side  (r1_side)
  );

  // ---------------------------------------------------------------- t1: scale to speed_limit
  logic        t1_vld_r;
  side_b_t     t1_side_r;
  vec62_t      t1_num_r;
  logic [31:0] t1_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) t1_vld_r <= 1'b0;
    else if (adv) t1_vld_r <= r1_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_side_r.cmd   <= r1_side.cmd;
      t1_side_r.dneg  <= r1_side.dneg;
      t1_side_r.dzero <= (r1_root == '0);
      t1_side_r.v     <= r1_side.v;
      t1_side_r.nv    <= r1_side.nv;
      t1_den_r        <= r1_root;
      for (int i = 0; i < 3; i++) begin
        t1_num_r[i] <= 62'(r1_side.n[i]) * 62'(speed_r);
      end
    end
  end

  logic    q1_vld;
  vec31_t  q1_quo;
  side_b_t q1_side;

  ssf_div #(.SIDE_W($bits(side_b_t))) u_div_des (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (t1_vld_r),
    .in_num    (t1_num_r),
    .in_den    (t1_den_r),
    .in_side   (t1_side_r),
    .out_valid (q1_vld),
    .out_quo   (q1_quo),
    .out_side  (q1_side)
  );

  // ---------------------------------------------------------------- t2: signed desired vector
  logic       t2_vld_r;
  logic [1:0] t2_cmd_r;
  vec32_t     t2_des_r;
  vec32_t     t2_v_r;
  vec32_t     t2_nv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) t2_vld_r <= 1'b0;
    else if (adv) t2_vld_r <= q1_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_cmd_r <= q1_side.cmd;
      t2_v_r   <= q1_side.v;
      t2_nv_r  <= q1_side.nv;
      for (int i = 0; i < 3; i++) begin
        // target on the position: zero desired vector
        if (q1_side.dzero) t2_des_r[i] <= '0;
        else if (q1_side.dneg[i]) t2_des_r[i] <= 32'(-{1'b0, q1_quo[i]});
        else t2_des_r[i] <= {1'b0, q1_quo[i]};
      end
    end
  end

  // ---------------------------------------------------------------- t3: steering = desired - velocity
  logic       t3_vld_r;
  logic [1:0] t3_cmd_r;
  vec33_t     t3_st_r;
  vec32_t     t3_nv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) t3_vld_r <= 1'b0;
    else if (adv) t3_vld_r <= t2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t3_cmd_r <= t2_cmd_r;
      t3_nv_r  <= t2_nv_r;
      for (int i = 0; i < 3; i++) begin
        t3_st_r[i] <= {t2_des_r[i][31], t2_des_r[i]} - {t2_v_r[i][31], t2_v_r[i]};
      end
    end
  end

  // ---------------------------------------------------------------- u1: |steering|
  logic       u1_vld_r;
  logic [1:0] u1_cmd_r;
  vec33_t     u1_st_r;
  vec33_t     u1_m_r;
  logic [2:0] u1_sneg_r;
  vec32_t     u1_nv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) u1_vld_r <= 1'b0;
    else if (adv) u1_vld_r <= t3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u1_cmd_r <= t3_cmd_r;
      u1_st_r  <= t3_st_r;
      u1_nv_r  <= t3_nv_r;
      for (int i = 0; i < 3; i++) begin
        u1_m_r[i]    <= abs33(t3_st_r[i]);
        u1_sneg_r[i] <= t3_st_r[i][32];
      end
    end
  end

  // ---------------------------------------------------------------- u2: max
  logic        u2_vld_r;
  logic [1:0]  u2_cmd_r;
  vec33_t      u2_st_r;
  vec33_t      u2_m_r;
  logic [32:0] u2_mx_r;
  logic [2:0]  u2_sneg_r;
  vec32_t      u2_nv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) u2_vld_r <= 1'b0;
    else if (adv) u2_vld_r <= u1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u2_cmd_r  <= u1_cmd_r;
      u2_st_r   <= u1_st_r;
      u2_m_r    <= u1_m_r;
      u2_mx_r   <= max3(u1_m_r);
      u2_sneg_r <= u1_sneg_r;
      u2_nv_r   <= u1_nv_r;
    end
  end

  // ---------------------------------------------------------------- u3: shift amounts
  logic       u3_vld_r;
  logic [1:0] u3_cmd_r;
  vec33_t     u3_st_r;
  vec33_t     u3_m_r;
  logic [1:0] u3_down_r;
  logic [4:0] u3_up_r;
  logic [2:0] u3_sneg_r;
  vec32_t     u3_nv_r;
  logic [1:0] u2_down;

  assign u2_down = down_of(u2_mx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) u3_vld_r <= 1'b0;
    else if (adv) u3_vld_r <= u2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u3_cmd_r  <= u2_cmd_r;
      u3_st_r   <= u2_st_r;
      u3_m_r    <= u2_m_r;
      u3_down_r <= u2_down;
      u3_up_r   <= up_of(u2_mx_r, u2_down);
      u3_sneg_r <= u2_sneg_r;
      u3_nv_r   <= u2_nv_r;
    end
  end

  // ---------------------------------------------------------------- u4: normalize
  logic    u4_vld_r;
  side_c_t u4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) u4_vld_r <= 1'b0;
    else if (adv) u4_vld_r <= u3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u4_side_r.cmd  <= u3_cmd_r;
      u4_side_r.sneg <= u3_sneg_r;
      u4_side_r.st   <= u3_st_r;
      u4_side_r.nv   <= u3_nv_r;
      u4_side_r.up   <= u3_up_r;
      u4_side_r.down <= u3_down_r;
      for (int i = 0; i < 3; i++) begin
        u4_side_r.n[i] <= 31'((u3_m_r[i] >> u3_down_r) << u3_up_r);
      end
    end
  end

  // ---------------------------------------------------------------- u5: squares
  logic    u5_vld_r;
  side_c_t u5_side_r;
  vec62_t  u5_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) u5_vld_r <= 1'b0;
    else if (adv) u5_vld_r <= u4_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u5_side_r <= u4_side_r;
      for (int i = 0; i < 3; i++) begin
        u5_sq_r[i] <= 62'(u4_side_r.n[i]) * 62'(u4_side_r.n[i]);
      end
    end
  end

  // ---------------------------------------------------------------- u6: sum of squares
  logic        u6_vld_r;
  side_c_t     u6_side_r;
  logic [63:0] u6_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) u6_vld_r <= 1'b0;
    else if (adv) u6_vld_r <= u5_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u6_side_r <= u5_side_r;
      u6_sum_r  <= 64'(u5_sq_r[0]) + 64'(u5_sq_r[1]) + 64'(u5_sq_r[2]);
    end
  end

  // ---------------------------------------------------------------- length of the steering vector
  logic        r2_vld;
  logic [31:0] r2_root;
  side_c_t     r2_side;

  ssf_isqrt #(.SIDE_W($bits(side_c_t))) u_len_st (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (u6_vld_r),
    .in_rad    (u6_sum_r),
    .in_side   (u6_side_r),
    .out_valid (r2_vld),
    .out_root  (r2_root),
    .out_side  (r2_side)
  );

  // ---------------------------------------------------------------- w1: clamp test, scale to force_limit
  // length compared with both sides brought to the same scale; a zero
  // steering vector has length zero and is never clamped
  logic        w1_vld_r;
  side_d_t     w1_side_r;
  vec62_t      w1_num_r;
  logic [31:0] w1_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) w1_vld_r <= 1'b0;
    else if (adv) w1_vld_r <= r2_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1_side_r.cmd   <= r2_side.cmd;
      w1_side_r.sneg  <= r2_side.sneg;
      w1_side_r.st    <= r2_side.st;
      w1_side_r.nv    <= r2_side.nv;
      w1_side_r.clamp <= (62'(r2_root) << r2_side.down) > (62'(force_r) << r2_side.up);
      w1_den_r        <= r2_root;
      for (int i = 0; i < 3; i++) begin
        w1_num_r[i] <= 62'(r2_side.n[i]) * 62'(force_r);
      end
    end
  end

  logic    q2_vld;
  vec31_t  q2_quo;
  side_d_t q2_side;

  ssf_div #(.SIDE_W($bits(side_d_t))) u_div_st (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (w1_vld_r),
    .in_num    (w1_num_r),
    .in_den    (w1_den_r),
    .in_side   (w1_side_r),
    .out_valid (q2_vld),
    .out_quo   (q2_quo),
    .out_side  (q2_side)
  );

  // ---------------------------------------------------------------- output register
  vec32_t fo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (q2_side.cmd != ssf_pkg::CMD_SEEK) begin
        fo[i] = '0;
      end else if (q2_side.clamp) begin
        fo[i] = q2_side.sneg[i] ? 32'(-{1'b0, q2_quo[i]}) : {1'b0, q2_quo[i]};
      end else if (!q2_side.st[i][32] && q2_side.st[i][31]) begin
        fo[i] = 32'h7FFFFFFF;  // saturate high
      end else if (q2_side.st[i][32] && !q2_side.st[i][31]) begin
        fo[i] = 32'h80000000;  // saturate low
      end else begin
        fo[i] = q2_side.st[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= q2_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.force_x        <= fo[0];
      out_data_r.force_y        <= fo[1];
      out_data_r.force_z        <= fo[2];
      out_data_r.new_velocity_x <= q2_side.nv[0];
      out_data_r.new_velocity_y <= q2_side.nv[1];
      out_data_r.new_velocity_z <= q2_side.nv[2];
    end
  end

endmodule

// File: dv/tb_top.sv
// testbench for the seek steering force block: directed table, random items, predictor check
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int PIPE_LAT = 144;
  localparam logic [1:0] CMD_ODD = 2'd3;
  localparam logic [2:0] ADDR_SPEED = 3'd0;
  localparam logic [2:0] ADDR_FORCE = 3'd4;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  ssf_pkg::ssf_in_t in_data;
  ssf_pkg::ssf_out_t out_data;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  seek_steering_force_top #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of the two limits
  logic [30:0] speed_lim, force_lim;
  ssf_pkg::ssf_out_t steer_expect_q[$];
  int err_count;
  int send_idle_pct, recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous fixed limit, far beyond the slowest correct run
  initial begin
    #20ms;
    $display("tb_top failed");
    $finish;
  end

  function automatic logic [63:0] mag_of(input logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // shift magnitudes into [2^30, 2^31) and take the length; zero vector returns 0
  function automatic bit vec_length(input logic [63:0] m[3], output logic [63:0] n[3],
                                    output int up, output int dn, output logic [63:0] len);
    logic [63:0] mx;
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    up = 0;
    dn = 0;
    len = 0;
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1;
      dn++;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      up++;
    end
    for (int i = 0; i < 3; i++) n[i] = (m[i] >> dn) << up;
    len = root_floor(n[0] * n[0] + n[1] * n[1] + n[2] * n[2]);
    return 1;
  endfunction

  function automatic logic signed [63:0] rescale(input logic [63:0] n, input logic [63:0] r,
                                                 input logic [63:0] len, input bit neg);
    logic signed [63:0] v;
    v = (n * r) / len;
    return neg ? -v : v;
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic ssf_pkg::ssf_out_t steer_predict(input ssf_pkg::ssf_in_t it);
    logic signed [63:0] tg[3], ps[3], vl[3], des[3], st[3], fc[3], nv[3];
    logic [63:0] m[3], n[3], len, sq;
    int up, dn;
    ssf_pkg::ssf_out_t r;
    tg = '{it.target_x, it.target_y, it.target_z};
    ps = '{it.position_x, it.position_y, it.position_z};
    vl = '{it.velocity_x, it.velocity_y, it.velocity_z};
    for (int i = 0; i < 3; i++) begin
      nv[i] = vl[i];
      fc[i] = 0;
      des[i] = 0;
    end
    if (it.command == ssf_pkg::CMD_SEEK) begin
      for (int i = 0; i < 3; i++) m[i] = mag_of(tg[i] - ps[i]);
      if (vec_length(m, n, up, dn, len))
        for (int i = 0; i < 3; i++)
          des[i] = rescale(n[i], speed_lim, len, (tg[i] - ps[i]) < 0);
      for (int i = 0; i < 3; i++) begin
        st[i] = des[i] - vl[i];
        m[i] = mag_of(st[i]);
        fc[i] = st[i];
      end
      if (vec_length(m, n, up, dn, len) &&
          ((len << dn) > ({33'd0, force_lim} << up)))
        for (int i = 0; i < 3; i++) fc[i] = rescale(n[i], force_lim, len, st[i] < 0);
    end else if (it.command != ssf_pkg::CMD_CTRL) begin
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = mag_of(vl[i]);
        sq += m[i] * m[i];
      end
      for (int i = 0; i < 3; i++)
        nv[i] = (sq > (64'd1 << (2 * FRAC))) ? vl[i] / 10 : 0;
    end
    r.force_x = clip32(fc[0]);
    r.force_y = clip32(fc[1]);
    r.force_z = clip32(fc[2]);
    r.new_velocity_x = nv[0][31:0];
    r.new_velocity_y = nv[1][31:0];
    r.new_velocity_z = nv[2][31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  // result checker: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    ssf_pkg::ssf_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (steer_expect_q.size() == 0) begin
        report_mismatch("unexpected result", out_data.force_x, 32'd0);
      end else begin
        e = steer_expect_q.pop_front();
        if (out_data.force_x !== e.force_x) report_mismatch("force_x", out_data.force_x, e.force_x);
        if (out_data.force_y !== e.force_y) report_mismatch("force_y", out_data.force_y, e.force_y);
        if (out_data.force_z !== e.force_z) report_mismatch("force_z", out_data.force_z, e.force_z);
        if (out_data.new_velocity_x !== e.new_velocity_x)
          report_mismatch("new_velocity_x", out_data.new_velocity_x, e.new_velocity_x);
        if (out_data.new_velocity_y !== e.new_velocity_y)
          report_mismatch("new_velocity_y", out_data.new_velocity_y, e.new_velocity_y);
        if (out_data.new_velocity_z !== e.new_velocity_z)
          report_mismatch("new_velocity_z", out_data.new_velocity_z, e.new_velocity_z);
      end
    end
  end

  // receiver stall, redrawn every cycle
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // apb write: setup then access, pready always high
  task automatic reg_write(input logic [2:0] addr, input logic [30:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {1'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_SPEED) speed_lim = val;
    else force_lim = val;
  endtask

  // offer one item, hold it until accepted, then note its expected result
  task automatic send_item(input ssf_pkg::ssf_in_t it, input bit typed,
                           input ssf_pkg::ssf_out_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    steer_expect_q.push_back(typed ? typed_res : steer_predict(it));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (steer_expect_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word;
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(262144) - 131072;
      3: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic ssf_pkg::ssf_in_t rand_item;
    ssf_pkg::ssf_in_t it;
    int k;
    it.command = $urandom_range(99) < 60 ? ssf_pkg::CMD_SEEK : 2'($urandom_range(3));
    it.target_x = rand_word();
    it.target_y = rand_word();
    it.target_z = rand_word();
    it.position_x = rand_word();
    it.position_y = rand_word();
    it.position_z = rand_word();
    it.velocity_x = rand_word();
    it.velocity_y = rand_word();
    it.velocity_z = rand_word();
    k = $urandom_range(9);
    // sometimes target on the position, sometimes small velocities near length 1
    if (k == 0) begin
      it.target_x = it.position_x;
      it.target_y = it.position_y;
      it.target_z = it.position_z;
    end else if (k == 1) begin
      it.velocity_x = $urandom_range(80000) - 40000;
      it.velocity_y = $urandom_range(80000) - 40000;
      it.velocity_z = $urandom_range(80000) - 40000;
    end
    return it;
  endfunction

  // directed table
  typedef struct {
    ssf_pkg::ssf_in_t it;
    bit typed;
    ssf_pkg::ssf_out_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic ssf_pkg::ssf_in_t mk(input logic [1:0] c, input logic [31:0] t,
                                          input logic [31:0] p, input logic [31:0] v);
    ssf_pkg::ssf_in_t it;
    it.command = c;
    it.target_x = t; it.target_y = t; it.target_z = t;
    it.position_x = p; it.position_y = p; it.position_z = p;
    it.velocity_x = v; it.velocity_y = v; it.velocity_z = v;
    return it;
  endfunction

  function automatic void add_row(input ssf_pkg::ssf_in_t it, input bit typed,
                                  input ssf_pkg::ssf_out_t res);
    dir_row_t r;
    r.it = it;
    r.typed = typed;
    r.res = res;
    dir_rows.push_back(r);
  endfunction

  initial begin
    ssf_pkg::ssf_in_t it;
    ssf_pkg::ssf_out_t z;
    err_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    speed_lim = 31'd65536;
    force_lim = 31'd131072;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; typed results where they are obvious
    z = '0;
    add_row(mk(ssf_pkg::CMD_SEEK, 0, 0, 0), 1, z);            // all zero, no force
    add_row(mk(ssf_pkg::CMD_CTRL, 32'h7fffffff, 32'h80000000, 0), 1, z);
    it = mk(ssf_pkg::CMD_CTRL, 5, 7, 32'h80000000);
    z.new_velocity_x = 32'h80000000; z.new_velocity_y = 32'h80000000;
    z.new_velocity_z = 32'h80000000;
    add_row(it, 1, z);                                        // controlled passes velocity
    z = '0;
    add_row(mk(ssf_pkg::CMD_STILL, 0, 0, 32'h00008000), 1, z); // slow, zeroed
    add_row(mk(ssf_pkg::CMD_STILL, 0, 0, 32'h00010000), 0, z); // length above 1
    it = mk(ssf_pkg::CMD_STILL, 0, 0, 0);
    it.velocity_x = 32'h00010000;
    add_row(it, 1, z);                                        // exactly 1, zeroed
    add_row(mk(ssf_pkg::CMD_STILL, 0, 0, 32'h80000000), 0, z);
    add_row(mk(CMD_ODD, 1, 2, 32'h7fffffff), 0, z);           // treated as still
    add_row(mk(ssf_pkg::CMD_SEEK, 32'h7fffffff, 32'h80000000, 0), 0, z);
    add_row(mk(ssf_pkg::CMD_SEEK, 32'h80000000, 32'h7fffffff, 32'h7fffffff), 0, z);
    add_row(mk(ssf_pkg::CMD_SEEK, 12345, 12345, 32'h00030000), 0, z); // target on position
    add_row(mk(ssf_pkg::CMD_SEEK, 32'h00050000, 0, 0), 0, z);
    add_row(mk(ssf_pkg::CMD_SEEK, 0, 32'h00050000, 32'hffff0000), 0, z);
    add_row(mk(ssf_pkg::CMD_SEEK, 32'hffffffff, 0, 32'h80000000), 0, z);
    add_row(mk(ssf_pkg::CMD_SEEK, 1, 0, 0), 0, z);

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
    drain();

    // random phases across limit settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin reg_write(ADDR_SPEED, 31'h7fffffff); reg_write(ADDR_FORCE, 31'h7fffffff); end
        1: begin reg_write(ADDR_SPEED, 31'd0); reg_write(ADDR_FORCE, 31'd0); end
        2: begin reg_write(ADDR_SPEED, 31'd65536); reg_write(ADDR_FORCE, 31'd131072); end
        default: begin
          reg_write(ADDR_SPEED, 31'($urandom));
          reg_write(ADDR_FORCE, 31'($urandom_range(1 << 24)));
        end
      endcase
      for (int j = 0; j < 4; j++) begin
        case (j)
          0: begin send_idle_pct = 0; recv_stall_pct = 0; end
          1: begin send_idle_pct = 48; recv_stall_pct = 0; end
          2: begin send_idle_pct = 0; recv_stall_pct = 48; end
          default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
        for (int n = 0; n < 19; n++) send_item(rand_item(), 0, z);
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
    end

    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
